FILE: rtl/core/c7s_pkg.sv
// Shared types, constants and segment decode for the seven-segment clock scanner.
package c7s_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int IDX_W      = 2;

	localparam logic [15:0] REFRESH_RESET = 16'd500;
	localparam logic [7:0]  COLON_BIT     = 8'h80;
	localparam logic [7:0]  FRAME_LOW     = 8'h00;

	// Digit position codes inside the display buffer
	localparam logic [IDX_W-1:0] POS_MIN_TENS  = 2'd0;
	localparam logic [IDX_W-1:0] POS_MIN_UNITS = 2'd1;
	localparam logic [IDX_W-1:0] POS_SEC_TENS  = 2'd2;
	localparam logic [IDX_W-1:0] POS_SEC_UNITS = 2'd3;

	typedef logic [NUM_DIGITS-1:0][7:0] digit_bytes_t;

	// Segment pattern a..g in bits 0..6 for one decimal digit
	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		begin
			unique case (d)
				4'd0: s = 8'h3F;
				4'd1: s = 8'h06;
				4'd2: s = 8'h5B;
				4'd3: s = 8'h4F;
				4'd4: s = 8'h66;
				4'd5: s = 8'h6D;
				4'd6: s = 8'h7D;
				4'd7: s = 8'h07;
				4'd8: s = 8'h7F;
				4'd9: s = 8'h6F;
				default: s = 8'h00;
			endcase
			return s;
		end
	endfunction

endpackage

FILE: rtl/core/c7s_digit_enc.sv
// Splits minutes and seconds into decimal digits and encodes the four display bytes.
module c7s_digit_enc
	import c7s_pkg::*;
(
	input  logic [5:0]   minutes,
	input  logic [5:0]   seconds,
	output digit_bytes_t digits
);

	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		begin
			t = 4'(v >= 6'd10) + 4'(v >= 6'd20) + 4'(v >= 6'd30)
				+ 4'(v >= 6'd40) + 4'(v >= 6'd50);
			return t;
		end
	endfunction

	logic [3:0] min_tens, min_units, sec_tens, sec_units;
	logic [5:0] min_tens_x10, sec_tens_x10;

	always_comb begin
		min_tens     = tens_of(minutes);
		sec_tens     = tens_of(seconds);
		min_tens_x10 = {min_tens[2:0], 3'b000} + {1'b0, min_tens, 1'b0};
		sec_tens_x10 = {sec_tens[2:0], 3'b000} + {1'b0, sec_tens, 1'b0};
		min_units    = 4'(minutes - min_tens_x10);
		sec_units    = 4'(seconds - sec_tens_x10);

		digits                = '0;
		digits[POS_MIN_TENS]  = seg_of(min_tens);
		digits[POS_MIN_UNITS] = seg_of(min_units) | COLON_BIT;
		digits[POS_SEC_TENS]  = seg_of(sec_tens);
		digits[POS_SEC_UNITS] = seg_of(sec_units);
	end

endmodule

FILE: rtl/core/clock_seven_segment_scanner.sv
// Top level of the multiplexed MM:SS seven-segment display scanner.
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  -------------------------------------------
//  in       sink       in_valid / in_stall     total_seconds[31:0]
//  out      source     out_valid / out_stall   digit_select, segments, shift_frame,
//                                              buffer_reloaded
//  cfg      sink       cfg_valid / cfg_ready   refresh_period[15:0]
//
//  One scan tick is taken every cycle while in_stall is low. After the capture stage,
//  the time split runs as mod-3600 folding (two stages), a reciprocal multiply for
//  minutes, a subtract for seconds, then the buffer read/write stage.
//  Reset clears the digit buffer, scan index, tick count and all stage valids, and
//  loads the refresh period with 500. cfg_ready is always high.
//  A stall on out backs up stage by stage; in_stall rises only when every stage is full.
module clock_seven_segment_scanner
	import c7s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] total_seconds,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  digit_select,
	output logic [7:0]  segments,
	output logic [15:0] shift_frame,
	output logic        buffer_reloaded,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] refresh_period
);

	// ---------------------------------------------------------------------------------
	// Configuration and per-tick control state
	// ---------------------------------------------------------------------------------
	logic [15:0]      period_q;
	logic [15:0]      count_q;
	logic [IDX_W-1:0] scan_q;
	logic [16:0]      count_inc;
	logic             reload_now;
	logic             in_xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= REFRESH_RESET;
		end else if (cfg_valid) begin
			period_q <= refresh_period;
		end
	end

	// Reload is decided at transfer time: count+1 against the period
	assign count_inc  = {1'b0, count_q} + 17'd1;
	assign reload_now = (count_inc >= {1'b0, period_q});
	assign in_xfer    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
		end else if (in_xfer) begin
			count_q <= reload_now ? 16'd0 : count_inc[15:0];
			scan_q  <= scan_q + IDX_W'(1);
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage flow control: a stage takes new data when empty or when it drains onward
	// ---------------------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

	assign out_rdy  = !out_valid_q || !out_stall;
	assign rdy5     = !v_s5 || out_rdy;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= in_valid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy4)    v_s4        <= v_s3;
			if (rdy5)    v_s5        <= v_s4;
			if (out_rdy) out_valid_q <= v_s5;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: capture the tick with its digit index and reload decision
	// ---------------------------------------------------------------------------------
	logic [31:0]      t_s1;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic             rld_s1, rld_s2, rld_s3, rld_s4, rld_s5;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			t_s1   <= total_seconds;
			idx_s1 <= scan_q;
			rld_s1 <= reload_now;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: t mod 3600 = t[3:0] + 16 * ((t >> 4) mod 225).
	// Fold the 28-bit quotient bytewise using 2^8, 2^16, 2^24 = 31, 61, 91 (mod 225).
	// ---------------------------------------------------------------------------------
	logic [14:0] fold1;
	logic [14:0] fold1_s2;
	logic [3:0]  lo_s2;

	assign fold1 = 15'(t_s1[11:4])
		+ 15'(t_s1[19:12]) * 15'd31
		+ 15'(t_s1[27:20]) * 15'd61
		+ 15'(t_s1[31:28]) * 15'd91;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			fold1_s2 <= fold1;
			lo_s2    <= t_s1[3:0];
			idx_s2   <= idx_s1;
			rld_s2   <= rld_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 3: two more folds bring the value under 675, then a compare-subtract
	// finishes mod 225 and forms the remainder within the hour.
	// ---------------------------------------------------------------------------------
	logic [11:0] fold2;
	logic [9:0]  fold3;
	logic [9:0]  mod225;
	logic [11:0] hour_rem_s3, hour_rem_s4;

	always_comb begin
		fold2 = 12'(fold1_s2[7:0]) + 12'(fold1_s2[14:8]) * 12'd31;
		fold3 = 10'(fold2[7:0]) + 10'(fold2[11:8]) * 10'd31;
		priority if (fold3 >= 10'd450) begin
			mod225 = fold3 - 10'd450;
		end else if (fold3 >= 10'd225) begin
			mod225 = fold3 - 10'd225;
		end else begin
			mod225 = fold3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			hour_rem_s3 <= {mod225[7:0], lo_s2};
			idx_s3      <= idx_s2;
			rld_s3      <= rld_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 4: minutes = floor(r * 2185 / 2^17), exact for r below 3600
	// ---------------------------------------------------------------------------------
	logic [23:0] min_prod;
	logic [5:0]  min_s4, min_s5;
	logic [5:0]  sec_s5;
	logic [11:0] min_x60;

	assign min_prod = 24'(hour_rem_s3) * 24'd2185;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			min_s4      <= min_prod[22:17];
			hour_rem_s4 <= hour_rem_s3;
			idx_s4      <= idx_s3;
			rld_s4      <= rld_s3;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 5: seconds = r - 60 * minutes
	// ---------------------------------------------------------------------------------
	assign min_x60 = {min_s4, 6'b000000} - {4'b0000, min_s4, 2'b00};

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			min_s5 <= min_s4;
			sec_s5 <= 6'(hour_rem_s4 - min_x60);
			idx_s5 <= idx_s4;
			rld_s5 <= rld_s4;
		end
	end

	// ---------------------------------------------------------------------------------
	// Output stage: read the buffer entry first, then overwrite on a reload tick.
	// Earlier ticks have already written by the time a tick reaches this stage.
	// ---------------------------------------------------------------------------------
	digit_bytes_t new_digits;
	logic [7:0]   store_q [NUM_DIGITS];
	logic         out_load;

	logic [IDX_W-1:0] sel_q;
	logic [7:0]       seg_q;
	logic             rld_q;

	c7s_digit_enc u_enc (
		.minutes (min_s5),
		.seconds (sec_s5),
		.digits  (new_digits)
	);

	assign out_load = out_rdy && v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				store_q[i] <= 8'h00;
			end
		end else if (out_load && rld_s5) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				store_q[i] <= new_digits[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sel_q <= idx_s5;
			seg_q <= store_q[idx_s5];
			rld_q <= rld_s5;
		end
	end

	assign out_valid       = out_valid_q;
	assign digit_select    = sel_q;
	assign segments        = seg_q;
	assign shift_frame     = {seg_q, FRAME_LOW};
	assign buffer_reloaded = rld_q;

endmodule

FILE: tb/sv/clock_seven_segment_scanner_checker.sv
// Scoreboard for the seven-segment scanner: predicts each scan result and compares it.
`timescale 1ns / 1ps

module clock_seven_segment_scanner_checker
	import c7s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] total_seconds,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  digit_select,
	input  logic [7:0]  segments,
	input  logic [15:0] shift_frame,
	input  logic        buffer_reloaded,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] refresh_period,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  digit;
		logic [7:0]  seg;
		logic [15:0] frame;
		logic        reload;
	} scan_result_t;

	// Segments a..g for decimal digits 0..9, colon bit clear
	localparam logic [7:0] DIGIT_GLYPH [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	scan_result_t expected_scans[$];
	logic [7:0]   shown_digits [NUM_DIGITS];
	logic [1:0]   scan_pos;
	logic [15:0]  ticks_since_reload;
	logic [15:0]  reload_period;
	int           bad_count;

	// Emit the current digit, then advance the scan and maybe refill from the time.
	task automatic predict_tick(input logic [31:0] secs);
		scan_result_t r;
		int unsigned  mins;
		int unsigned  sec_part;
		logic [16:0]  next_count;
		r.digit = scan_pos;
		r.seg = shown_digits[scan_pos];
		r.frame = {shown_digits[scan_pos], FRAME_LOW};
		scan_pos = scan_pos + 2'd1;
		next_count = {1'b0, ticks_since_reload} + 17'd1;
		if (next_count >= {1'b0, reload_period}) begin
			ticks_since_reload = 16'd0;
			mins = (secs / 60) % 60;
			sec_part = secs % 60;
			shown_digits[POS_MIN_TENS] = DIGIT_GLYPH[mins / 10];
			shown_digits[POS_MIN_UNITS] = DIGIT_GLYPH[mins % 10] | COLON_BIT;
			shown_digits[POS_SEC_TENS] = DIGIT_GLYPH[sec_part / 10];
			shown_digits[POS_SEC_UNITS] = DIGIT_GLYPH[sec_part % 10];
			r.reload = 1'b1;
		end else begin
			ticks_since_reload = next_count[15:0];
			r.reload = 1'b0;
		end
		expected_scans.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			foreach (shown_digits[i])
				shown_digits[i] = 8'h00;
			scan_pos = 2'd0;
			ticks_since_reload = 16'd0;
			reload_period = REFRESH_RESET;
			expected_scans.delete();
			bad_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reload_period = refresh_period;
			if (in_valid && !in_stall)
				predict_tick(total_seconds);
			if (out_valid && !out_stall) begin
				if (expected_scans.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: unexpected result sel=%0d seg=%02h frame=%04h rel=%0b",
							$realtime, digit_select, segments, shift_frame, buffer_reloaded);
				end else begin
					want = expected_scans.pop_front();
					if (digit_select !== want.digit || segments !== want.seg ||
						shift_frame !== want.frame || buffer_reloaded !== want.reload) begin
						bad_count++;
						if (bad_count <= 10)
							$display("%0t: mismatch exp sel=%0d seg=%02h frame=%04h rel=%0b, got sel=%0d seg=%02h frame=%04h rel=%0b",
								$realtime, want.digit, want.seg, want.frame, want.reload,
								digit_select, segments, shift_frame, buffer_reloaded);
					end
				end
			end
		end
		// Publish with NBAs so the stimulus side samples a stable value
		pending <= expected_scans.size();
		mismatches <= bad_count;
	end

endmodule

FILE: tb/sv/clock_seven_segment_scanner_tb.sv
// Top-level testbench for the seven-segment scanner: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module clock_seven_segment_scanner_tb;

	// Drain allowance used for the waits after every predicted result has come back
	localparam int LATENCY     = 5;
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] total_seconds = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  digit_select;
	logic [7:0]  segments;
	logic [15:0] shift_frame;
	logic        buffer_reloaded;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] refresh_period = 16'd0;

	int   mismatches;
	int   pending;
	int   cycle_count = 0;
	int   phase_id = 0;
	logic hold_off = 1'b0;

	clock_seven_segment_scanner u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.total_seconds   (total_seconds),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.digit_select    (digit_select),
		.segments        (segments),
		.shift_frame     (shift_frame),
		.buffer_reloaded (buffer_reloaded),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.refresh_period  (refresh_period)
	);

	clock_seven_segment_scanner_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.total_seconds   (total_seconds),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.digit_select    (digit_select),
		.segments        (segments),
		.shift_frame     (shift_frame),
		.buffer_reloaded (buffer_reloaded),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.refresh_period  (refresh_period),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Random idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Mix full-range counters with values around minute and hour rollovers
	function automatic logic [31:0] pick_seconds();
		int unsigned base;
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 7199);
			3: begin
				base = $urandom_range(0, 1000) * 60;
				return base + ($urandom_range(0, 1) ? 59 : 0);
			end
			4: return $urandom_range(1, 1000) * 3600 - $urandom_range(0, 1);
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 120)
				: $urandom_range(0, 120);
		endcase
	endfunction

	// Offer one scan tick and hold it until the block takes the transfer.
	task automatic send_tick(input logic [31:0] secs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		total_seconds <= secs;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_random_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_tick(pick_seconds());
	endtask

	// Drop valid and wait until every predicted result has come back.
	// Step the clock first so the pending count already includes the last transfer.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] period);
		cfg_valid <= 1'b1;
		refresh_period <= period;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: alternate quiet runs and stall runs; the pressure hold forces stall.
	initial begin
		int  run;
		int  r;
		bit  stall_run;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				stall_run = 1'b0;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
			end else if (r < 92) begin
				stall_run = 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				stall_run = 1'b1;
				run = $urandom_range(10, 60);
			end
			repeat (run) begin
				@(posedge clk);
				out_stall <= stall_run | hold_off;
			end
		end
	end

	// Pressure: hold the output off long enough for the pipeline to fill and
	// push back on the input while the sender keeps offering.
	initial begin
		wait (phase_id == 7);
		repeat (10) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		logic [31:0] directed_secs [$];
		directed_secs = '{
			32'd0, 32'd3599, 32'd83, 32'd2706, 32'd1068, 32'd1979, 32'd3487, 32'd1471,
			32'd372, 32'd2385, 32'd3050, 32'd183, 32'd884, 32'd60, 32'd3600, 32'd59,
			32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
			32'hAAAA_AAAA
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Run on the reset period first: one refill at tick 500, zeros before it
		phase_id = 1;
		send_random_ticks(520);

		// Period 1: refill every tick, each shown byte is from the tick before
		wait_idle();
		phase_id = 2;
		write_period(16'd1);
		foreach (directed_secs[i])
			send_tick(directed_secs[i]);

		// Period zero also refills on every tick
		wait_idle();
		phase_id = 3;
		write_period(16'd0);
		send_random_ticks(100);

		// Largest period: no refill, count climbs well past small periods
		wait_idle();
		phase_id = 4;
		write_period(16'hFFFF);
		send_random_ticks(150);

		// Drop the period below the running count: next tick must refill
		wait_idle();
		phase_id = 5;
		write_period(16'd7);
		send_random_ticks(200);

		wait_idle();
		phase_id = 6;
		write_period(16'($urandom_range(2, 40)));
		send_random_ticks(200);

		wait_idle();
		write_period(16'($urandom_range(41, 1000)));
		send_random_ticks(150);

		wait_idle();
		write_period(16'd3);
		phase_id = 7;
		send_random_ticks(150);

		wait_idle();
		repeat (4 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
